### rtl/bcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared types, constants and message text for the byte command FIFO.
// ----------------------------------------------------------------------------
package bcf_pkg;

   localparam int DEPTH_DEFAULT = 8;
   localparam int CMDQ_DEPTH    = 2;
   localparam int CMDQ_PTR_W    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CMDQ_CNT_W    = $clog2(CMDQ_DEPTH + 1);

   localparam logic [7:0] CH_POP   = 8'h20;
   localparam logic [7:0] CH_FLUSH = 8'h2C;
   localparam logic [7:0] CH_DUMP  = 8'h2E;

   localparam int MSG_IDX_W = 5;

   localparam logic [MSG_IDX_W-1:0] LEN_FULL    = 5'd15;
   localparam logic [MSG_IDX_W-1:0] LEN_EMPTY   = 5'd16;
   localparam logic [MSG_IDX_W-1:0] LEN_FLUSHED = 5'd18;

   localparam logic [8*15-1:0] TXT_FULL    = "Buffer is full!";
   localparam logic [8*16-1:0] TXT_EMPTY   = "Buffer is empty!";
   localparam logic [8*18-1:0] TXT_FLUSHED = "Buffer is flushed!";

   typedef enum logic [1:0] {
      OP_STORE,
      OP_POP,
      OP_FLUSH,
      OP_DUMP
   } op_type;

   typedef enum logic [1:0] {
      MSG_FULL,
      MSG_EMPTY,
      MSG_FLUSHED
   } msg_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

   function automatic logic [MSG_IDX_W-1:0] msg_len(input msg_type msg);
      logic [MSG_IDX_W-1:0] len;
      case (msg)
         MSG_FULL:    len = LEN_FULL;
         MSG_EMPTY:   len = LEN_EMPTY;
         MSG_FLUSHED: len = LEN_FLUSHED;
         default:     len = LEN_FULL;
      endcase
      return len;
   endfunction

   // first character sits in the top byte of each string
   function automatic logic [7:0] msg_char(input msg_type msg,
                                           input logic [MSG_IDX_W-1:0] idx);
      logic [MSG_IDX_W-1:0] pos;
      logic [7:0]           ch;
      pos = msg_len(msg) - 5'd1 - idx;
      case (msg)
         MSG_FULL:    ch = TXT_FULL[8*pos +: 8];
         MSG_EMPTY:   ch = TXT_EMPTY[8*pos +: 8];
         MSG_FLUSHED: ch = TXT_FLUSHED[8*pos +: 8];
         default:     ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

### rtl/bcf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/bcf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_front
// Takes received words, decodes the command characters and queues them.
// ----------------------------------------------------------------------------
module bcf_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [7:0]       rx_byte,
   output logic                  full,
   output logic                  cmd_valid,
   output bcf_pkg::cmd_type      cmd,
   input  wire logic             cmd_take
);

   bcf_pkg::cmd_type                    q_ff [bcf_pkg::CMDQ_DEPTH];
   logic [bcf_pkg::CMDQ_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [bcf_pkg::CMDQ_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [bcf_pkg::CMDQ_CNT_W-1:0]      cnt_ff, cnt_in;
   bcf_pkg::cmd_type                    cmd_in;
   logic                                do_push;
   logic                                do_pop;

   function automatic logic [bcf_pkg::CMDQ_PTR_W-1:0] ptr_inc(
      input logic [bcf_pkg::CMDQ_PTR_W-1:0] p);
      logic [bcf_pkg::CMDQ_PTR_W-1:0] n;
      if (p == bcf_pkg::CMDQ_PTR_W'(bcf_pkg::CMDQ_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   always_comb begin
      cmd_in.data = rx_byte;
      unique case (rx_byte)
         bcf_pkg::CH_POP:   cmd_in.op = bcf_pkg::OP_POP;
         bcf_pkg::CH_FLUSH: cmd_in.op = bcf_pkg::OP_FLUSH;
         bcf_pkg::CH_DUMP:  cmd_in.op = bcf_pkg::OP_DUMP;
         default:           cmd_in.op = bcf_pkg::OP_STORE;
      endcase
   end

   assign full      = (cnt_ff == bcf_pkg::CMDQ_CNT_W'(bcf_pkg::CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule
`default_nettype wire

### rtl/bcf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_back
// Carries out queued commands on the byte store and sends the result words
// through a one-word output register.
// ----------------------------------------------------------------------------
module bcf_back #(
   parameter int DEPTH = bcf_pkg::DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire bcf_pkg::cmd_type cmd,
   output logic                  cmd_take,
   output logic                  out_empty,
   input  wire logic             out_pop,
   output logic [7:0]            out_byte,
   output logic                  out_last
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DATA,
      ST_TEXT
   } state_type;

   state_type                       state_ff, state_in;
   logic [PTR_W-1:0]                head_ff, head_in;
   logic [PTR_W-1:0]                tail_ff, tail_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [CNT_W-1:0]                remain_ff, remain_in;
   bcf_pkg::msg_type                msg_ff, msg_in;
   logic [bcf_pkg::MSG_IDX_W-1:0]   idx_ff, idx_in;
   logic                            out_valid_ff, out_valid_in;
   logic [7:0]                      tx_ff, tx_in;
   logic                            last_ff, last_in;

   logic                            out_free;
   logic                            text_last;
   logic                            wr_en;
   logic                            rd_en;
   logic [PTR_W-1:0]                rd_addr;
   logic [7:0]                      rd_data;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   bcf_ram #(
      .WIDTH  (8),
      .DEPTH  (DEPTH),
      .ADDR_W (PTR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (cmd.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !out_valid_ff || out_pop;
   assign text_last = (idx_ff == bcf_pkg::msg_len(msg_ff) - 5'd1);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      msg_in       = msg_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !out_pop;
      tx_in        = tx_ff;
      last_in      = last_ff;
      cmd_take     = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               unique case (cmd.op)
                  bcf_pkg::OP_STORE: begin
                     if (count_ff < CNT_W'(DEPTH)) begin
                        wr_en    = 1'b1;
                        tail_in  = ptr_inc(tail_ff);
                        count_in = count_ff + 1'b1;
                     end else begin
                        msg_in   = bcf_pkg::MSG_FULL;
                        idx_in   = '0;
                        state_in = ST_TEXT;
                     end
                  end
                  bcf_pkg::OP_FLUSH: begin
                     count_in = '0;
                     tail_in  = head_ff;
                     msg_in   = bcf_pkg::MSG_FLUSHED;
                     idx_in   = '0;
                     state_in = ST_TEXT;
                  end
                  bcf_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        msg_in   = bcf_pkg::MSG_EMPTY;
                        idx_in   = '0;
                        state_in = ST_TEXT;
                     end else begin
                        rd_en     = 1'b1;
                        remain_in = CNT_W'(1);
                        state_in  = ST_READ;
                     end
                  end
                  bcf_pkg::OP_DUMP: begin
                     // dump of an empty store sends nothing
                     if (count_ff != '0) begin
                        rd_en     = 1'b1;
                        remain_in = count_ff;
                        state_in  = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               tx_in        = rd_data;
               last_in      = (remain_ff == CNT_W'(1));
               head_in      = ptr_inc(head_ff);
               count_in     = count_ff - 1'b1;
               remain_in    = remain_ff - 1'b1;
               if (remain_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = ptr_inc(head_ff);
                  state_in = ST_READ;
               end
            end
         end
         ST_TEXT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               tx_in        = bcf_pkg::msg_char(msg_ff, idx_ff);
               last_in      = text_last;
               idx_in       = idx_ff + 1'b1;
               if (text_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      remain_ff <= remain_in;
      msg_ff    <= msg_in;
      idx_ff    <= idx_in;
      tx_ff     <= tx_in;
      last_ff   <= last_in;
   end

   assign out_empty = !out_valid_ff;
   assign out_byte  = tx_ff;
   assign out_last  = last_ff;

endmodule
`default_nettype wire

### rtl/byte_command_fifo_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_command_fifo_core
// Byte FIFO controlled by command characters in the received stream.
// ----------------------------------------------------------------------------
// Input side: a word is taken when req_push is high and req_full is low.
// A space pops the oldest stored byte, a comma flushes the store, a period
// dumps every stored byte oldest first; any other byte is stored, or dropped
// with the text "Buffer is full!" when DEPTH bytes are held.
// Result side: each transmitted byte is a word on rsp_tx_byte with rsp_last
// high on the final word of a command; it is taken when rsp_pop is high and
// rsp_empty is low.
// A two-entry command queue sits between decode and execution, so words keep
// arriving while the executor works. The executor takes one command at a time:
// a store is done in the idle state as the command is taken, message text
// goes out at one word per cycle while the receiver takes the words, and each
// stored byte passes through ST_READ and ST_DATA, as the store RAM read data is
// registered. Every result word goes through the output register.
// Reset empties the command queue, the store and the output register.
// When the receiver stalls the output register holds its word, the executor
// waits, and the command queue fills until req_full is raised.
// ----------------------------------------------------------------------------
module byte_command_fifo_core #(
   parameter int DEPTH = bcf_pkg::DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_tx_byte,
   output logic            rsp_last
);

   logic             cmd_valid;
   logic             cmd_take;
   bcf_pkg::cmd_type cmd;

   bcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .rx_byte   (req_rx_byte),
      .full      (req_full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   bcf_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .out_empty (rsp_empty),
      .out_pop   (rsp_pop),
      .out_byte  (rsp_tx_byte),
      .out_last  (rsp_last)
   );

endmodule
`default_nettype wire
